### sv/osr_pkg.sv
package osr_pkg;

  // Fixed sizes of the stack and of the payload fields.
  localparam int unsigned STACK_DEPTH = 512;
  localparam int unsigned WORD_WIDTH  = 32;
  localparam int unsigned ADDR_WIDTH  = 9;
  localparam int unsigned CNT_WIDTH   = 10;

  // Operation codes.
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_INDEX = 3'd3;
  localparam logic [2:0] OP_ROLL  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEPTH_LIMIT = 2'd0;
  localparam logic [1:0] CFG_LIMIT_CHECK = 2'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] push_word;
    logic [8:0]  distance_from_top;
    logic [9:0]  block_size;
    logic signed [31:0] shift_count;
  } osr_in_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [1:0]  status;
    logic [9:0]  depth_now;
  } osr_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RRET,
    S_DIV,
    S_LD,
    S_LC,
    S_RD,
    S_WR,
    S_DONE
  } osr_state_t;

endpackage

### sv/operand_stack_with_roll.sv
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     osr_pkg::osr_in_t
// out_      output     out_valid / out_ready   osr_pkg::osr_out_t
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Push, clear, unknown operations, refused items and rolls with a zero block
// size or shift go straight to the done state; pop and index first pass the
// read-return state for the registered read of the word memory. A roll that
// needs the remainder waits on the remainder unit and then moves each of the
// block's words with one read and one write. Reset is synchronous and empties
// the stack; the word memory is not cleared. in_ready is high only while idle,
// and a finished item waits in the output register until out_ready.
module operand_stack_with_roll (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  osr_pkg::osr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output osr_pkg::osr_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_data
);

  import osr_pkg::*;

  osr_state_t state_r, state_nxt;

  logic [9:0]  count_r, count_nxt;
  logic [9:0]  limit_r;
  logic        chk_r;
  logic [9:0]  blk_r, blk_nxt;
  logic [8:0]  shf_r, shf_nxt;
  logic        neg_r, neg_nxt;
  logic [8:0]  base_r, base_nxt;
  logic [8:0]  start_r, start_nxt;
  logic [8:0]  cur_r, cur_nxt;
  logic [8:0]  dest_r, dest_nxt;
  logic [9:0]  moves_r, moves_nxt;
  logic [31:0] carry_r, carry_nxt;
  logic [31:0] rd_r, rd_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  osr_out_t    out_r, out_nxt;

  logic        accept;
  logic        slot_free;
  logic        ram_we, ram_re;
  logic [8:0]  ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;
  logic        div_start, div_done;
  logic [31:0] div_mag;
  logic [9:0]  div_rem;
  logic [9:0]  dsum;
  logic [8:0]  dest_c;
  logic        push_ok;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  // Next position in the rotation cycle.
  assign dsum   = {1'b0, cur_r} + {1'b0, shf_r};
  assign dest_c = (dsum >= blk_r) ? 9'(dsum - blk_r) : dsum[8:0];

  assign push_ok = !((chk_r && count_r >= limit_r) ||
                     (count_r >= CNT_WIDTH'(STACK_DEPTH)));
  assign div_mag = in_data.shift_count[31] ? 32'(-in_data.shift_count)
                                           : in_data.shift_count;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DONE;
          if (in_data.operation == OP_POP && count_r != '0) begin
            state_nxt = S_RRET;
          end else if (in_data.operation == OP_INDEX &&
                       {1'b0, in_data.distance_from_top} < count_r) begin
            state_nxt = S_RRET;
          end else if (in_data.operation == OP_ROLL &&
                       in_data.block_size <= count_r &&
                       in_data.block_size != '0 && in_data.shift_count != '0) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_RRET: state_nxt = S_DONE;
      S_DIV: begin
        if (div_done) begin
          state_nxt = (div_rem == '0) ? S_DONE : S_LD;
        end
      end
      S_LD: state_nxt = S_LC;
      S_LC: state_nxt = S_RD;
      S_RD: begin
        if (dest_c == start_r) begin
          state_nxt = (moves_r + 10'd1 == blk_r) ? S_DONE : S_LD;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: state_nxt = S_RD;
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls for each state.
  always_comb begin
    count_nxt     = count_r;
    blk_nxt       = blk_r;
    shf_nxt       = shf_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    dest_nxt      = dest_r;
    moves_nxt     = moves_r;
    carry_nxt     = carry_r;
    rd_nxt        = rd_r;
    st_nxt        = st_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[8:0];
    ram_wdata     = in_data.push_word;
    ram_re        = 1'b0;
    ram_raddr     = 9'(count_r - 10'd1);
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_nxt  = '0;
          st_nxt  = ST_OK;
          blk_nxt = in_data.block_size;
          neg_nxt = in_data.shift_count[31];
          case (in_data.operation)
            OP_PUSH: begin
              if (push_ok) begin
                ram_we    = 1'b1;
                count_nxt = count_r + 10'd1;
              end else begin
                st_nxt = ST_OVERFLOW;
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                count_nxt = count_r - 10'd1;
              end
            end
            OP_CLEAR: count_nxt = '0;
            OP_INDEX: begin
              if ({1'b0, in_data.distance_from_top} >= count_r) begin
                st_nxt = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = 9'(count_r - 10'd1 - {1'b0, in_data.distance_from_top});
              end
            end
            OP_ROLL: begin
              if (in_data.block_size > count_r) begin
                st_nxt = ST_RANGE;
              end else if (in_data.block_size != '0 && in_data.shift_count != '0) begin
                div_start = 1'b1;
                base_nxt  = 9'(count_r - in_data.block_size);
              end
            end
            default: ;
          endcase
        end
      end
      S_RRET: rd_nxt = ram_rdata;
      S_DIV: begin
        if (div_done) begin
          shf_nxt   = neg_r ? 9'(blk_r - div_rem) : div_rem[8:0];
          start_nxt = '0;
          cur_nxt   = '0;
          moves_nxt = '0;
        end
      end
      S_LD: begin
        ram_re    = 1'b1;
        ram_raddr = base_r + cur_r;
      end
      S_LC: carry_nxt = ram_rdata;
      S_RD: begin
        dest_nxt = dest_c;
        if (dest_c == start_r) begin
          // Cycle closes: the carried word lands on the start position.
          ram_we    = 1'b1;
          ram_waddr = base_r + dest_c;
          ram_wdata = carry_r;
          moves_nxt = moves_r + 10'd1;
          start_nxt = start_r + 9'd1;
          cur_nxt   = start_r + 9'd1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = base_r + dest_c;
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + dest_r;
        ram_wdata = carry_r;
        carry_nxt = ram_rdata;
        cur_nxt   = dest_r;
        moves_nxt = moves_r + 10'd1;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.read_word = rd_r;
          out_nxt.status    = st_r;
          out_nxt.depth_now = count_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= 10'd512;
      chk_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEPTH_LIMIT: limit_r <= cfg_data;
          CFG_LIMIT_CHECK: chk_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
    blk_r   <= blk_nxt;
    shf_r   <= shf_nxt;
    neg_r   <= neg_nxt;
    base_r  <= base_nxt;
    start_r <= start_nxt;
    cur_r   <= cur_nxt;
    dest_r  <= dest_nxt;
    moves_r <= moves_nxt;
    carry_r <= carry_nxt;
    rd_r    <= rd_nxt;
    st_r    <= st_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  osr_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  osr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (in_data.block_size),
    .done     (div_done),
    .remainder(div_rem)
  );

`ifndef NO_ASSERTIONS
  // The word count never passes the stack's capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_WIDTH'(STACK_DEPTH))
    else $error("word count beyond capacity");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("ready right after an accepted item");

  // The remainder unit only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("remainder unit finished outside its wait state");

  // A roll never moves more words than its block holds.
  a_moves_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_WR) |-> (moves_r < blk_r))
    else $error("roll moved too many words");
`endif

endmodule

### sv/osr_ram.sv
module osr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/osr_div.sv
module osr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [9:0]  remainder
);

  logic [31:0] quo_r, quo_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [9:0]  dvs_r, dvs_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [10:0] trial;

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 10'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[9:0];
      end
      step_nxt = step_r + 5'd1;
      if (step_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
